// ===== rtl/tcce_pkg.sv =====
// Shared types and constants of the text console cursor engine.
package tcce_pkg;

  // Command codes of the input channel.
  localparam logic [1:0] MODE_PUT  = 2'd0;
  localparam logic [1:0] MODE_BKSP = 2'd1;
  localparam logic [1:0] MODE_SET  = 2'd2;

  // Result operation codes.
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_STATUS = 2'd2;

  // Status codes carried by the final result of a command.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_COL = 2'd1;
  localparam logic [1:0] ST_BAD_ROW = 2'd2;

  // Configuration register indexes.
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CFG_WRAP     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_SCROLL   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_AUTOINC  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ATTR     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_BKSP_COL = 3'd4;

  // Character codes and reset attribute.
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] ATTR_RESET = 8'd11;

  // Job handed from the front to the back through the queue.
  typedef struct packed {
    logic        has_write;
    logic [10:0] wr_addr;
    logic [7:0]  wr_char;
    logic        has_clear;
    logic [10:0] clr_addr;
    logic [7:0]  attr;
    logic [6:0]  col;
    logic [4:0]  row;
    logic [4:0]  origin;
    logic [1:0]  status;
  } job_t;

endpackage

// ===== rtl/text_console_cursor_engine.sv =====
// Text console cursor engine: top level joining front end, queue and sequencer.
//
// Each command (put character, backspace, set cursor) produces one to three
// result transfers: a cell write, a row clear when the screen scrolls, and
// always a final status transfer marked by out_last. Every result carries
// the cursor and ring origin as they stand after the command. The front end
// updates the cursor in the cycle a command is accepted and can take one
// command per clock while its two-entry job queue has room; the result
// sequencer then emits one result per clock while the receiver is ready,
// so a command occupies the output for one transfer per result (1 to 3, 3
// at most for a put that scrolls). The sustained rate is set by that output sequencer.
// Configuration writes take effect on the next command.
module text_console_cursor_engine import tcce_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [7:0]         in_char_code,
  input  logic [7:0]         in_set_col,
  input  logic [7:0]         in_set_row,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_op,
  output logic [10:0]        out_cell_addr,
  output logic [7:0]         out_char_out,
  output logic [7:0]         out_attr_out,
  output logic [6:0]         out_cursor_col,
  output logic [4:0]         out_cursor_row,
  output logic [4:0]         out_origin_row,
  output logic [1:0]         out_status,
  output logic               out_last
);

  logic q_push, q_ready, q_pop, q_head_valid;
  job_t q_job, q_head_job;

  // Command acceptance and cursor tracking.
  tcce_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_char_code (in_char_code),
    .in_set_col   (in_set_col),
    .in_set_row   (in_set_row),
    .q_ready      (q_ready),
    .q_push       (q_push),
    .q_job        (q_job)
  );

  // Job queue decoupling the two sides.
  tcce_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ready (q_ready),
    .push_job   (q_job),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  // Result expansion and output register.
  tcce_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (q_head_valid),
    .head_job       (q_head_job),
    .pop            (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_op         (out_op),
    .out_cell_addr  (out_cell_addr),
    .out_char_out   (out_char_out),
    .out_attr_out   (out_attr_out),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_origin_row (out_origin_row),
    .out_status     (out_status),
    .out_last       (out_last)
  );

endmodule

// ===== rtl/tcce_front.sv =====
// Command front end: configuration registers, cursor state and job building.
module tcce_front import tcce_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [7:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [7:0]         in_char_code,
  input  logic [7:0]         in_set_col,
  input  logic [7:0]         in_set_row,
  input  logic               q_ready,
  output logic               q_push,
  output job_t               q_job
);

  localparam logic [6:0] COL_LAST = 7'(COLUMNS - 1);
  localparam logic [4:0] ROW_LAST = 5'(ROWS - 1);

  logic       wrap_en_r, scroll_en_r, autoinc_en_r;
  logic [7:0] attr_r;
  logic [6:0] bksp_col_r;
  logic [6:0] cur_col_r, cur_col_nxt;
  logic [4:0] cur_row_r, cur_row_nxt;
  logic [4:0] origin_r, origin_nxt;

  logic       at_bottom, nl_scroll, do_scroll, has_write;
  logic [4:0] nl_row, origin_inc, wr_row;
  logic [5:0] phys_sum;
  logic [4:0] phys_row;
  logic [11:0] wr_full, clr_full;
  logic [1:0] status;
  logic [7:0] wr_char;

  assign in_ready = q_ready;
  assign q_push   = in_valid & q_ready;

  // Next-line move shared by wrap-around and newline.
  assign at_bottom  = (cur_row_r == ROW_LAST);
  assign nl_scroll  = at_bottom & scroll_en_r;
  assign nl_row     = at_bottom ? ROW_LAST : cur_row_r + 5'd1;
  assign origin_inc = (origin_r == ROW_LAST) ? 5'd0 : origin_r + 5'd1;

  // Cursor update per command.
  always_comb begin
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    do_scroll   = 1'b0;
    has_write   = 1'b0;
    status      = ST_OK;
    wr_char     = CH_SPACE;
    case (in_mode)
      MODE_PUT: begin
        if (in_char_code == CH_NEWLINE) begin
          if (wrap_en_r) begin
            cur_row_nxt = nl_row;
            cur_col_nxt = 7'd0;
            do_scroll   = nl_scroll;
          end else begin
            cur_col_nxt = COL_LAST;
          end
        end else begin
          has_write = 1'b1;
          wr_char   = in_char_code;
          if (autoinc_en_r) begin
            if (cur_col_r == COL_LAST) begin
              if (wrap_en_r) begin
                cur_row_nxt = nl_row;
                cur_col_nxt = 7'd0;
                do_scroll   = nl_scroll;
              end
            end else begin
              cur_col_nxt = cur_col_r + 7'd1;
            end
          end
        end
      end
      MODE_BKSP: begin
        has_write = 1'b1;
        if (cur_col_r == 7'd0) begin
          if (cur_row_r != 5'd0) begin
            if (wrap_en_r) cur_row_nxt = cur_row_r - 5'd1;
            cur_col_nxt = COL_LAST;
          end
        end else if (bksp_col_r == 7'd0 || cur_col_r > bksp_col_r) begin
          cur_col_nxt = cur_col_r - 7'd1;
        end
      end
      MODE_SET: begin
        if ({1'b0, in_set_col} >= 9'(COLUMNS)) begin
          status = ST_BAD_COL;
        end else if ({1'b0, in_set_row} >= 9'(ROWS)) begin
          status = ST_BAD_ROW;
        end else begin
          cur_col_nxt = in_set_col[6:0];
          cur_row_nxt = in_set_row[4:0];
        end
      end
      default: ;
    endcase
    origin_nxt = do_scroll ? origin_inc : origin_r;
  end

  // A put writes at the old cursor, a backspace at the new one.
  assign wr_row   = (in_mode == MODE_BKSP) ? cur_row_nxt : cur_row_r;
  assign phys_sum = {1'b0, origin_r} + {1'b0, wr_row};
  assign phys_row = (phys_sum >= 6'(ROWS)) ? 5'(phys_sum - 6'(ROWS)) : phys_sum[4:0];
  assign wr_full  = 12'(phys_row) * 12'(COLUMNS)
                  + 12'((in_mode == MODE_BKSP) ? cur_col_nxt : cur_col_r);
  // The cleared row is the old origin, which becomes the bottom line.
  assign clr_full = 12'(origin_r) * 12'(COLUMNS);

  always_comb begin
    q_job.has_write = has_write;
    q_job.wr_addr   = wr_full[10:0];
    q_job.wr_char   = wr_char;
    q_job.has_clear = do_scroll;
    q_job.clr_addr  = clr_full[10:0];
    q_job.attr      = attr_r;
    q_job.col       = cur_col_nxt;
    q_job.row       = cur_row_nxt;
    q_job.origin    = origin_nxt;
    q_job.status    = status;
  end

  // Configuration and cursor state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_en_r    <= 1'b1;
      scroll_en_r  <= 1'b1;
      autoinc_en_r <= 1'b1;
      attr_r       <= ATTR_RESET;
      bksp_col_r   <= 7'd0;
      cur_col_r    <= 7'd0;
      cur_row_r    <= 5'd0;
      origin_r     <= 5'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WRAP:     wrap_en_r    <= cfg_wdata[0];
          CFG_SCROLL:   scroll_en_r  <= cfg_wdata[0];
          CFG_AUTOINC:  autoinc_en_r <= cfg_wdata[0];
          CFG_ATTR:     attr_r       <= cfg_wdata;
          CFG_BKSP_COL: bksp_col_r   <= cfg_wdata[6:0];
          default: ;
        endcase
      end
      if (q_push) begin
        cur_col_r <= cur_col_nxt;
        cur_row_r <= cur_row_nxt;
        origin_r  <= origin_nxt;
      end
    end
  end

endmodule

// ===== rtl/tcce_queue.sv =====
// Two-entry job queue between the front end and the result sequencer.
module tcce_queue import tcce_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic push_ready,
  input  job_t push_job,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign push_ready = (count_r != 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_job   = mem_r[rd_ptr_r];

  // Pointer and fill tracking.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

// ===== rtl/tcce_back.sv =====
// Result sequencer: expands the job at the queue head into result transfers.
module tcce_back import tcce_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  job_t        head_job,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_op,
  output logic [10:0] out_cell_addr,
  output logic [7:0]  out_char_out,
  output logic [7:0]  out_attr_out,
  output logic [6:0]  out_cursor_col,
  output logic [4:0]  out_cursor_row,
  output logic [4:0]  out_origin_row,
  output logic [1:0]  out_status,
  output logic        out_last
);

  logic        wr_done_r, clr_done_r;
  logic        out_valid_r;
  logic [1:0]  op_r, status_r;
  logic [10:0] addr_r;
  logic [7:0]  char_r, attr_r;
  logic [6:0]  col_r;
  logic [4:0]  row_r, origin_r;
  logic        last_r;

  logic        load, emit_write, emit_clear;

  // The output register takes a new result when empty or being drained.
  assign load       = head_valid & (~out_valid_r | out_ready);
  assign emit_write = head_job.has_write & ~wr_done_r;
  assign emit_clear = ~emit_write & head_job.has_clear & ~clr_done_r;
  assign pop        = load & ~emit_write & ~emit_clear;

  // Progress through the results of the head job.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_done_r   <= 1'b0;
      clr_done_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        wr_done_r  <= 1'b0;
        clr_done_r <= 1'b0;
      end else if (load) begin
        if (emit_write) wr_done_r  <= 1'b1;
        if (emit_clear) clr_done_r <= 1'b1;
      end
      if (load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      col_r    <= head_job.col;
      row_r    <= head_job.row;
      origin_r <= head_job.origin;
      if (emit_write) begin
        op_r     <= OP_WRITE;
        addr_r   <= head_job.wr_addr;
        char_r   <= head_job.wr_char;
        attr_r   <= head_job.attr;
        status_r <= ST_OK;
        last_r   <= 1'b0;
      end else if (emit_clear) begin
        op_r     <= OP_CLEAR;
        addr_r   <= head_job.clr_addr;
        char_r   <= CH_SPACE;
        attr_r   <= head_job.attr;
        status_r <= ST_OK;
        last_r   <= 1'b0;
      end else begin
        op_r     <= OP_STATUS;
        addr_r   <= 11'd0;
        char_r   <= 8'd0;
        attr_r   <= 8'd0;
        status_r <= head_job.status;
        last_r   <= 1'b1;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_op         = op_r;
  assign out_cell_addr  = addr_r;
  assign out_char_out   = char_r;
  assign out_attr_out   = attr_r;
  assign out_cursor_col = col_r;
  assign out_cursor_row = row_r;
  assign out_origin_row = origin_r;
  assign out_status     = status_r;
  assign out_last       = last_r;

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the text console cursor engine.
module testbench;
  import tcce_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS = 25;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 100000;
  localparam int REPORT_MAX = 10;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // One console command as offered on the input channel.
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] char_code;
    logic [7:0] set_col;
    logic [7:0] set_row;
  } console_cmd_t;

  // One frame-memory operation or status on the result channel.
  typedef struct packed {
    logic [1:0]  op;
    logic [10:0] cell_addr;
    logic [7:0]  char_out;
    logic [7:0]  attr_out;
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [4:0]  origin_row;
    logic [1:0]  status;
    logic        last;
  } frame_op_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [7:0]         cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_mode = '0;
  logic [7:0]         in_char_code = '0;
  logic [7:0]         in_set_col = '0;
  logic [7:0]         in_set_row = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         out_op;
  logic [10:0]        out_cell_addr;
  logic [7:0]         out_char_out;
  logic [7:0]         out_attr_out;
  logic [6:0]         out_cursor_col;
  logic [4:0]         out_cursor_row;
  logic [4:0]         out_origin_row;
  logic [1:0]         out_status;
  logic               out_last;

  // Predicted console state and register copies.
  int cur_col = 0;
  int cur_row = 0;
  int ring_org = 0;
  bit wrap_on = 1'b1;
  bit scroll_on = 1'b1;
  bit autoinc_on = 1'b1;
  logic [7:0] attr_byte = ATTR_RESET;
  int stop_col = 0;

  console_cmd_t pending_cmds[$];
  console_cmd_t offered;
  frame_op_t    cmd_ops[$];
  frame_op_t    frame_ops_due[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int mismatch_count = 0;
  int cycle_count = 0;

  text_console_cursor_engine #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_char_code  (in_char_code),
    .in_set_col    (in_set_col),
    .in_set_row    (in_set_row),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_op        (out_op),
    .out_cell_addr (out_cell_addr),
    .out_char_out  (out_char_out),
    .out_attr_out  (out_attr_out),
    .out_cursor_col(out_cursor_col),
    .out_cursor_row(out_cursor_row),
    .out_origin_row(out_origin_row),
    .out_status    (out_status),
    .out_last      (out_last)
  );

  always #5 clk = ~clk;

  // A cell write at the current cursor, mapped through the ring origin.
  function automatic frame_op_t cell_write(input logic [7:0] ch);
    frame_op_t r;
    int addr;
    r = '0;
    addr = ((ring_org + cur_row) % ROWS) * COLUMNS + cur_col;
    r.op = OP_WRITE;
    r.cell_addr = addr[10:0];
    r.char_out = ch;
    r.attr_out = attr_byte;
    return r;
  endfunction

  // With wrap on, move to column 0 of the next line; on the bottom row this may scroll,
  // which clears the old top physical row and advances the origin.
  function automatic void line_feed();
    frame_op_t r;
    int addr;
    if (wrap_on) begin
      if (cur_row + 1 >= ROWS) begin
        if (scroll_on) begin
          r = '0;
          addr = (ring_org % ROWS) * COLUMNS;
          r.op = OP_CLEAR;
          r.cell_addr = addr[10:0];
          r.char_out = CH_SPACE;
          r.attr_out = attr_byte;
          cmd_ops.push_back(r);
          ring_org = (ring_org + 1) % ROWS;
        end
        cur_row = ROWS - 1;
      end else begin
        cur_row = cur_row + 1;
      end
      cur_col = 0;
    end
  endfunction

  // Work out the operations one accepted command produces and queue them.
  function automatic void predict_frame_ops(input console_cmd_t c);
    frame_op_t r;
    logic [1:0] st;
    int k;
    st = ST_OK;
    cmd_ops.delete();
    case (c.mode)
      MODE_PUT: begin
        if (c.char_code == CH_NEWLINE) begin
          if (wrap_on) line_feed();
          else cur_col = COLUMNS - 1;
        end else begin
          cmd_ops.push_back(cell_write(c.char_code));
          if (autoinc_on) begin
            if (cur_col + 1 >= COLUMNS) line_feed();
            else cur_col = cur_col + 1;
          end
        end
      end
      MODE_BKSP: begin
        if (cur_col == 0) begin
          if (cur_row != 0) begin
            if (wrap_on) cur_row = cur_row - 1;
            cur_col = COLUMNS - 1;
          end
        end else if (stop_col == 0 || cur_col > stop_col) begin
          cur_col = cur_col - 1;
        end
        cmd_ops.push_back(cell_write(CH_SPACE));
      end
      MODE_SET: begin
        if (c.set_col >= COLUMNS) st = ST_BAD_COL;
        else if (c.set_row >= ROWS) st = ST_BAD_ROW;
        else begin
          cur_col = c.set_col;
          cur_row = c.set_row;
        end
      end
      default: begin
      end
    endcase
    r = '0;
    r.op = OP_STATUS;
    cmd_ops.push_back(r);
    // Every operation carries the cursor as it stands after the command.
    for (k = 0; k < cmd_ops.size(); k++) begin
      r = cmd_ops[k];
      r.cursor_col = cur_col[6:0];
      r.cursor_row = cur_row[4:0];
      r.origin_row = ring_org[4:0];
      r.status = (k == cmd_ops.size() - 1) ? st : ST_OK;
      r.last = (k == cmd_ops.size() - 1);
      frame_ops_due.push_back(r);
    end
  endfunction

  function automatic string describe(input frame_op_t r);
    return $sformatf("op=%0d addr=%0d ch=%02h attr=%02h col=%0d row=%0d org=%0d st=%0d last=%0b",
                     r.op, r.cell_addr, r.char_out, r.attr_out, r.cursor_col,
                     r.cursor_row, r.origin_row, r.status, r.last);
  endfunction

  // Random command, biased toward the bottom right corner so that wrapping
  // and scrolling come up often.
  function automatic console_cmd_t random_cmd();
    console_cmd_t c;
    int pick;
    pick = $urandom_range(99);
    c.mode = MODE_PUT;
    c.char_code = 8'($urandom_range(255));
    c.set_col = 8'($urandom_range(255));
    c.set_row = 8'($urandom_range(255));
    if (pick < 50) begin
      c.mode = MODE_PUT;
    end else if (pick < 60) begin
      c.char_code = CH_NEWLINE;
    end else if (pick < 75) begin
      c.mode = MODE_BKSP;
    end else if (pick < 96) begin
      c.mode = MODE_SET;
      if ($urandom_range(3) != 0) begin
        c.set_col = $urandom_range(1) ? 8'($urandom_range(COLUMNS - 1))
                                      : 8'($urandom_range(COLUMNS - 1, COLUMNS - 4));
        c.set_row = $urandom_range(1) ? 8'($urandom_range(ROWS - 1))
                                      : 8'($urandom_range(ROWS - 1, ROWS - 2));
      end
    end else begin
      c.mode = MODE_UNUSED;
    end
    return c;
  endfunction

  // Input driver: predicts each accepted transfer, then offers the next one.
  always @(posedge clk) begin : input_driver
    console_cmd_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_frame_ops(offered);
      if (!in_valid || in_ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_cmds.pop_front();
          offered = nxt;
          in_valid <= 1'b1;
          in_mode <= nxt.mode;
          in_char_code <= nxt.char_code;
          in_set_col <= nxt.set_col;
          in_set_row <= nxt.set_row;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result monitor: compare each transfer with the oldest expectation.
  always @(posedge clk) begin : result_monitor
    frame_op_t got;
    frame_op_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_op, out_cell_addr, out_char_out, out_attr_out, out_cursor_col,
             out_cursor_row, out_origin_row, out_status, out_last};
      if (frame_ops_due.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < REPORT_MAX)
          $display("unexpected result: %s", describe(got));
      end else begin
        want = frame_ops_due.pop_front();
        if (got !== want) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < REPORT_MAX) begin
            $display("mismatch: expected %s", describe(want));
            $display("          actual   %s", describe(got));
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WRAP:     wrap_on = data[0];
      CFG_SCROLL:   scroll_on = data[0];
      CFG_AUTOINC:  autoinc_on = data[0];
      CFG_ATTR:     attr_byte = data;
      CFG_BKSP_COL: stop_col = data[6:0];
      default: begin
      end
    endcase
  endtask

  task automatic set_config(input bit wrap, input bit scroll, input bit autoinc,
                            input logic [7:0] attr, input int stop);
    write_reg(CFG_WRAP, {7'd0, wrap});
    write_reg(CFG_SCROLL, {7'd0, scroll});
    write_reg(CFG_AUTOINC, {7'd0, autoinc});
    write_reg(CFG_ATTR, attr);
    write_reg(CFG_BKSP_COL, stop[7:0]);
  endtask

  task automatic queue_cmd(input logic [1:0] mode, input logic [7:0] ch,
                           input logic [7:0] col, input logic [7:0] row);
    console_cmd_t c;
    c.mode = mode;
    c.char_code = ch;
    c.set_col = col;
    c.set_row = row;
    pending_cmds.push_back(c);
  endtask

  // Wait until every command is sent and every expected result has come.
  task automatic drain();
    @(negedge clk);
    while (pending_cmds.size() != 0 || in_valid || frame_ops_due.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_random(input int count, input int send_pct, input int recv_pct);
    int k;
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    for (k = 0; k < count; k++) pending_cmds.push_back(random_cmd());
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed checks with the reset configuration.
    queue_cmd(MODE_SET, 8'h00, 8'd79, 8'd24);
    queue_cmd(MODE_PUT, 8'hFF, 8'h00, 8'h00);
    queue_cmd(MODE_PUT, CH_NEWLINE, 8'h00, 8'h00);
    queue_cmd(MODE_PUT, 8'h00, 8'h00, 8'h00);
    queue_cmd(MODE_SET, 8'h00, 8'd0, 8'd0);
    queue_cmd(MODE_BKSP, 8'h00, 8'h00, 8'h00);
    queue_cmd(MODE_SET, 8'h00, 8'd0, 8'd5);
    queue_cmd(MODE_BKSP, 8'h00, 8'h00, 8'h00);
    queue_cmd(MODE_SET, 8'h00, 8'd80, 8'd3);
    queue_cmd(MODE_SET, 8'h00, 8'd255, 8'd255);
    queue_cmd(MODE_SET, 8'h00, 8'd5, 8'd25);
    queue_cmd(MODE_SET, 8'h00, 8'd0, 8'd255);
    queue_cmd(MODE_UNUSED, 8'hAA, 8'h55, 8'hF0);
    queue_cmd(MODE_SET, 8'h00, 8'd10, 8'd3);
    queue_cmd(MODE_BKSP, 8'h00, 8'h00, 8'h00);
    drain();

    // Wrap off, with a backspace stop column.
    set_config(1'b0, 1'b1, 1'b1, 8'hFF, 5);
    queue_cmd(MODE_SET, 8'h00, 8'd79, 8'd2);
    queue_cmd(MODE_PUT, 8'h78, 8'h00, 8'h00);
    queue_cmd(MODE_PUT, CH_NEWLINE, 8'h00, 8'h00);
    queue_cmd(MODE_SET, 8'h00, 8'd0, 8'd3);
    queue_cmd(MODE_BKSP, 8'h00, 8'h00, 8'h00);
    queue_cmd(MODE_SET, 8'h00, 8'd5, 8'd1);
    queue_cmd(MODE_BKSP, 8'h00, 8'h00, 8'h00);
    queue_cmd(MODE_SET, 8'h00, 8'd6, 8'd1);
    queue_cmd(MODE_BKSP, 8'h00, 8'h00, 8'h00);
    drain();

    // Scroll and auto-increment off, stop column at its top value.
    set_config(1'b1, 1'b0, 1'b0, 8'h00, 79);
    queue_cmd(MODE_SET, 8'h00, 8'd79, 8'd24);
    queue_cmd(MODE_PUT, 8'h5A, 8'h00, 8'h00);
    queue_cmd(MODE_PUT, CH_NEWLINE, 8'h00, 8'h00);
    drain();

    // Random phases under varied settings and flow-control patterns.
    set_config(1'b1, 1'b1, 1'b1, ATTR_RESET, 0);
    run_random(35, 0, 0);
    set_config(1'b1, 1'b1, 1'b1, 8'($urandom_range(255)), $urandom_range(79));
    run_random(35, 45, 0);
    set_config(1'b0, 1'b1, 1'b1, 8'($urandom_range(255)), 0);
    run_random(35, 0, 45);
    set_config(1'b1, 1'b0, 1'b1, 8'($urandom_range(255)), $urandom_range(79, 64));
    run_random(35, 20, 20);

    // Long receiver hold-off while the sender keeps offering commands.
    set_config(1'b1, 1'b1, 1'b1, 8'hFF, 79);
    hold_req = hold_req + 1;
    run_random(35, 0, 0);

    set_config(1'b1, 1'b1, 1'b0, 8'h00, 0);
    run_random(30, 20, 20);

    repeat (20) @(posedge clk);
    // Results still owed at the end count as a failure too.
    if (mismatch_count == 0 && frame_ops_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tcce_pkg.sv
rtl/tcce_front.sv
rtl/tcce_queue.sv
rtl/tcce_back.sv
rtl/text_console_cursor_engine.sv
tb/testbench.sv
